>>> rtl/ecar_pkg.sv
// Shared widths, types and helpers for the tetrahedron edge couple area pipeline.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package ecar_pkg;

   localparam int IN_W        = 32;
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int OUT_W       = 63;

   // Derived datapath widths.
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int MAG_W  = PROD_W;
   localparam int LO_W   = MAG_W / 2;
   localparam int HI_W   = MAG_W - LO_W;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int ROOT_W = SUM_W / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int SHIFT  = FRAC_BITS + 1;
   localparam int SH_W   = ROOT_W + 1;
   localparam int CMP_W  = (SH_W > OUT_W) ? SH_W : OUT_W;

   typedef struct packed {
      logic [IN_W-1:0] x;
      logic [IN_W-1:0] y;
      logic [IN_W-1:0] z;
   } point_type;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic [MAG_W-1:0]         mag_type;
   typedef logic [SUM_W-1:0]         sum_type;
   typedef logic [ROOT_W-1:0]        root_type;

   // Sign-extend the low COORD_WIDTH bits of a raw coordinate.
   function automatic diff_type sext(input logic [IN_W-1:0] raw);
      logic signed [COORD_WIDTH-1:0] c;
      c = raw[COORD_WIDTH-1:0];
      return DIFF_W'(c);
   endfunction

endpackage
`default_nettype wire

>>> rtl/tet_edge_couple_area_unit.sv
// Top level of the tetrahedron edge couple area pipeline.
// Depends on ecar_pkg, ecar_front, ecar_square and ecar_isqrt.
//
// Usage: one edge record (tetrahedron centre, edge midpoint and the two
// adjacent face centres) enters on the req_ channel as one word; one word
// carrying the couple area leaves on the rsp_ channel. Both channels use a
// valid/ready handshake.
// Throughput is one word per cycle while the receiver keeps up. The pipeline
// has three front stages, three squaring stages, one stage
// per root bit of the square root pipeline and the output register.
// The whole pipeline advances together; when the receiver holds rsp_ready
// low with a result waiting, every stage holds and req_ready falls, so no
// word is lost or repeated.
// Synchronous reset clears all valid bits; data registers are not reset.
`default_nettype none
module tet_edge_couple_area_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [ecar_pkg::IN_W-1:0] req_tet_x,
   input  wire logic [ecar_pkg::IN_W-1:0] req_tet_y,
   input  wire logic [ecar_pkg::IN_W-1:0] req_tet_z,
   input  wire logic [ecar_pkg::IN_W-1:0] req_mid_x,
   input  wire logic [ecar_pkg::IN_W-1:0] req_mid_y,
   input  wire logic [ecar_pkg::IN_W-1:0] req_mid_z,
   input  wire logic [ecar_pkg::IN_W-1:0] req_face_a_x,
   input  wire logic [ecar_pkg::IN_W-1:0] req_face_a_y,
   input  wire logic [ecar_pkg::IN_W-1:0] req_face_a_z,
   input  wire logic [ecar_pkg::IN_W-1:0] req_face_b_x,
   input  wire logic [ecar_pkg::IN_W-1:0] req_face_b_y,
   input  wire logic [ecar_pkg::IN_W-1:0] req_face_b_z,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [ecar_pkg::OUT_W-1:0]     rsp_couple_area
);
   import ecar_pkg::*;

   logic       en;
   point_type  tet, mid, fa, fb;
   logic       front_valid, sq_valid, root_valid;
   mag_type    mag [2][3];
   sum_type    norm [2];
   root_type   root [2];
   logic [SH_W-1:0]  total;
   logic [CMP_W-1:0] scaled;
   logic [OUT_W-1:0] area_in;
   logic [OUT_W-1:0] area_ff;
   logic             rsp_valid_ff;

   // The pipeline moves whenever the output register is free or being read.
   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;

   assign tet = '{x: req_tet_x,    y: req_tet_y,    z: req_tet_z};
   assign mid = '{x: req_mid_x,    y: req_mid_y,    z: req_mid_z};
   assign fa  = '{x: req_face_a_x, y: req_face_a_y, z: req_face_a_z};
   assign fb  = '{x: req_face_b_x, y: req_face_b_y, z: req_face_b_z};

   ecar_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .tet       (tet),
      .mid       (mid),
      .fa        (fa),
      .fb        (fb),
      .out_valid (front_valid),
      .mag       (mag)
   );

   ecar_square u_square (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .mag       (mag),
      .out_valid (sq_valid),
      .norm      (norm)
   );

   ecar_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .norm      (norm),
      .out_valid (root_valid),
      .root      (root)
   );

   // Halve, rescale and saturate the sum of both magnitudes.
   always_comb begin
      total  = SH_W'(root[0]) + SH_W'(root[1]);
      scaled = CMP_W'(total >> SHIFT);
      if (scaled > CMP_W'({OUT_W{1'b1}})) begin
         area_in = {OUT_W{1'b1}};
      end else begin
         area_in = OUT_W'(scaled);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         area_ff <= area_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_couple_area = area_ff;

endmodule
`default_nettype wire

>>> rtl/ecar_front.sv
// Front end: coordinate differences, cross product terms and component magnitudes.
// Three register stages; depends on ecar_pkg.
`default_nettype none
module ecar_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire ecar_pkg::point_type  tet,
   input  wire ecar_pkg::point_type  mid,
   input  wire ecar_pkg::point_type  fa,
   input  wire ecar_pkg::point_type  fb,
   output logic                      out_valid,
   output ecar_pkg::mag_type         mag [2][3]
);
   import ecar_pkg::*;

   diff_type vec_ff [3][3];
   diff_type vec_in [3][3];
   prod_type p_ff [2][3];
   prod_type q_ff [2][3];
   prod_type p_in [2][3];
   prod_type q_in [2][3];
   mag_type  mag_ff [2][3];
   mag_type  mag_in [2][3];
   logic [2:0] vld_ff;

   // First stage: the three coordinate difference vectors.
   always_comb begin
      vec_in[0][0] = sext(tet.x) - sext(mid.x);
      vec_in[0][1] = sext(tet.y) - sext(mid.y);
      vec_in[0][2] = sext(tet.z) - sext(mid.z);
      vec_in[1][0] = sext(fa.x) - sext(tet.x);
      vec_in[1][1] = sext(fa.y) - sext(tet.y);
      vec_in[1][2] = sext(fa.z) - sext(tet.z);
      vec_in[2][0] = sext(fb.x) - sext(tet.x);
      vec_in[2][1] = sext(fb.y) - sext(tet.y);
      vec_in[2][2] = sext(fb.z) - sext(tet.z);
   end

   // Stage two: the two products of each cross product component.
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         for (int c = 0; c < 3; c++) begin
            p_in[p][c] = prod_type'(vec_ff[0][(c + 1) % 3]) *
                         prod_type'(vec_ff[p + 1][(c + 2) % 3]);
            q_in[p][c] = prod_type'(vec_ff[0][(c + 2) % 3]) *
                         prod_type'(vec_ff[p + 1][(c + 1) % 3]);
         end
      end
   end

   // Stage three: component difference and its magnitude.
   always_comb begin
      logic signed [PROD_W:0] dd;
      for (int p = 0; p < 2; p++) begin
         for (int c = 0; c < 3; c++) begin
            dd = {p_ff[p][c][PROD_W-1], p_ff[p][c]} - {q_ff[p][c][PROD_W-1], q_ff[p][c]};
            mag_in[p][c] = dd[PROD_W] ? MAG_W'(-dd) : MAG_W'(dd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
         p_ff   <= p_in;
         q_ff   <= q_in;
         mag_ff <= mag_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign mag       = mag_ff;

endmodule
`default_nettype wire

>>> rtl/ecar_square.sv
// Squares the cross product components from partial products and sums each norm.
// Three register stages; depends on ecar_pkg.
`default_nettype none
module ecar_square (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire ecar_pkg::mag_type    mag [2][3],
   output logic                      out_valid,
   output ecar_pkg::sum_type         norm [2]
);
   import ecar_pkg::*;

   logic [2*HI_W-1:0]      hh_ff [2][3];
   logic [HI_W+LO_W-1:0]   hl_ff [2][3];
   logic [2*LO_W-1:0]      ll_ff [2][3];
   logic [2*HI_W-1:0]      hh_in [2][3];
   logic [HI_W+LO_W-1:0]   hl_in [2][3];
   logic [2*LO_W-1:0]      ll_in [2][3];
   logic [SQ_W-1:0]        sq_ff [2][3];
   logic [SQ_W-1:0]        sq_in [2][3];
   sum_type                sum_ff [2];
   sum_type                sum_in [2];
   logic [2:0]             vld_ff;

   // Stage one: partial products of each square.
   always_comb begin
      logic [HI_W-1:0] hi;
      logic [LO_W-1:0] lo;
      for (int p = 0; p < 2; p++) begin
         for (int c = 0; c < 3; c++) begin
            hi = mag[p][c][MAG_W-1:LO_W];
            lo = mag[p][c][LO_W-1:0];
            hh_in[p][c] = (2*HI_W)'(hi) * (2*HI_W)'(hi);
            hl_in[p][c] = (HI_W+LO_W)'(hi) * (HI_W+LO_W)'(lo);
            ll_in[p][c] = (2*LO_W)'(lo) * (2*LO_W)'(lo);
         end
      end
   end

   // Stage two: assemble each square; the cross term counts twice.
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         for (int c = 0; c < 3; c++) begin
            sq_in[p][c] = (SQ_W'(hh_ff[p][c]) << (2 * LO_W)) +
                          (SQ_W'(hl_ff[p][c]) << (LO_W + 1)) +
                          SQ_W'(ll_ff[p][c]);
         end
      end
   end

   // Stage three: squared norm of each cross product.
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         sum_in[p] = SUM_W'(sq_ff[p][0]) + SUM_W'(sq_ff[p][1]) + SUM_W'(sq_ff[p][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff  <= hh_in;
         hl_ff  <= hl_in;
         ll_ff  <= ll_in;
         sq_ff  <= sq_in;
         sum_ff <= sum_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign norm      = sum_ff;

endmodule
`default_nettype wire

>>> rtl/ecar_isqrt.sv
// Pipelined exact integer square root of both norms, one root bit per stage.
// ROOT_W register stages; depends on ecar_pkg.
`default_nettype none
module ecar_isqrt (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire ecar_pkg::sum_type    norm [2],
   output logic                      out_valid,
   output ecar_pkg::root_type        root [2]
);
   import ecar_pkg::*;

   sum_type          rad_ff  [ROOT_W-1][2];
   logic [REM_W-1:0] rem_ff  [ROOT_W-1][2];
   root_type         root_ff [ROOT_W][2];
   logic [ROOT_W-1:0] vld_ff;

   // Valid bits travel alongside the digit stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= ROOT_W'({vld_ff, in_valid});
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      for (genvar l = 0; l < 2; l++) begin : g_lane
         sum_type          rad_src;
         logic [REM_W-1:0] rem_src;
         root_type         root_src;
         logic [REM_W-1:0] rem_sh;
         logic [REM_W-1:0] trial;
         logic             ge;

         if (k == 0) begin : g_first
            assign rad_src  = norm[l];
            assign rem_src  = '0;
            assign root_src = '0;
         end else begin : g_next
            assign rad_src  = rad_ff[k-1][l];
            assign rem_src  = rem_ff[k-1][l];
            assign root_src = root_ff[k-1][l];
         end

         // Bring down two radicand bits and try the next root digit.
         assign rem_sh = {rem_src[REM_W-3:0], rad_src[SUM_W-1 -: 2]};
         assign trial  = REM_W'({root_src, 2'b01});
         assign ge     = (rem_sh >= trial);

         always_ff @(posedge clock) begin
            if (en) begin
               root_ff[k][l] <= {root_src[ROOT_W-2:0], ge};
            end
         end

         if (k < ROOT_W - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k][l] <= ge ? (rem_sh - trial) : rem_sh;
                  rad_ff[k][l] <= rad_src << 2;
               end
            end
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign root[0]   = root_ff[ROOT_W-1][0];
   assign root[1]   = root_ff[ROOT_W-1][1];

endmodule
`default_nettype wire
